// ===== sv/mfp_pkg.sv =====
// Shared types, codes and character tables for the multipart form parser.
`default_nettype none
package mfp_pkg;

	localparam int MAX_BOUNDARY_BYTES = 48;
	localparam int BND_WORDS          = 6;
	localparam int BND_BYTES          = BND_WORDS * 8;
	localparam int QUEUE_DEPTH        = 4;
	localparam int DISP_LEN           = 19;
	localparam int CTYPE_LEN          = 12;
	localparam int DISP_SKIP          = 13;
	localparam int CTYPE_SKIP         = 2;

	localparam logic [7:0] CHR_CR    = 8'd13;
	localparam logic [7:0] CHR_LF    = 8'd10;
	localparam logic [7:0] CHR_DASH  = 8'h2d;
	localparam logic [7:0] CHR_EQ    = 8'h3d;
	localparam logic [7:0] CHR_QUOTE = 8'h22;

	localparam logic [2:0] REG_LEN   = 3'd0;
	localparam logic [2:0] REG_WORD0 = 3'd1;
	localparam logic [2:0] REG_WORD5 = 3'd6;

	typedef enum logic [2:0] {
		KIND_NAME  = 3'd0,
		KIND_FILE  = 3'd1,
		KIND_TYPE  = 3'd2,
		KIND_DATA  = 3'd3,
		KIND_PEND  = 3'd4,
		KIND_BEND  = 3'd5,
		KIND_TRUNC = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		PH_DASH1, PH_DASH2, PH_BOUND, PH_AFTER, PH_AFTER_DASH, PH_DISP, PH_SKIP,
		PH_CDVAL, PH_CDVAL_EQ, PH_LINE2, PH_TYPE, PH_TYPE_END, PH_DATA, PH_END
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_v;
		logic       file;
	} res_t;

	// Up to three results raised by one input byte, oldest in slot 0.
	typedef struct packed {
		logic [1:0]       cnt;
		res_t [2:0]       r;
	} bundle_t;

	function automatic logic [7:0] disp_char(input logic [5:0] idx);
		logic [7:0] c;
		unique case (idx)
			6'd0:  c = "c";
			6'd1:  c = "o";
			6'd2:  c = "n";
			6'd3:  c = "t";
			6'd4:  c = "e";
			6'd5:  c = "n";
			6'd6:  c = "t";
			6'd7:  c = "-";
			6'd8:  c = "d";
			6'd9:  c = "i";
			6'd10: c = "s";
			6'd11: c = "p";
			6'd12: c = "o";
			6'd13: c = "s";
			6'd14: c = "i";
			6'd15: c = "t";
			6'd16: c = "i";
			6'd17: c = "o";
			6'd18: c = "n";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ctype_char(input logic [5:0] idx);
		logic [7:0] c;
		unique case (idx)
			6'd0:  c = "c";
			6'd1:  c = "o";
			6'd2:  c = "n";
			6'd3:  c = "t";
			6'd4:  c = "e";
			6'd5:  c = "n";
			6'd6:  c = "t";
			6'd7:  c = "-";
			6'd8:  c = "t";
			6'd9:  c = "y";
			6'd10: c = "p";
			6'd11: c = "e";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mfp_front.sv =====
// Front end: header parser and content window, one byte per cycle while accept is high, into bundles.
`default_nettype none
module mfp_front #(
	parameter int MAX_BOUNDARY_BYTES = mfp_pkg::MAX_BOUNDARY_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [7:0]                        byte_value,
	input  wire logic                              body_last,
	input  wire logic [5:0]                        boundary_len,
	input  wire logic [mfp_pkg::BND_BYTES*8-1:0]   boundary,
	output mfp_pkg::bundle_t                       bundle
);
	localparam int WIN = MAX_BOUNDARY_BYTES + 4;
	localparam int FW  = $clog2(WIN + 1);
	localparam int LW  = $clog2(MAX_BOUNDARY_BYTES + 1) > 6 ? $clog2(MAX_BOUNDARY_BYTES + 1) : 6;

	mfp_pkg::phase_t ph_q, ph_d;
	logic [5:0]      match_q, match_d;
	logic [3:0]      skip_q, skip_d;
	logic            inq_q, inq_d, take_q, take_d, file_q, file_d, cr_q, cr_d;
	logic [FW-1:0]   fill_q, fill_d;
	logic [7:0]      win_q [WIN];
	logic [7:0]      win_d [WIN];
	logic [7:0]      nw    [WIN];

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] bnd_at(input int k);
		logic [7:0] v;
		v = 8'd0;
		if (k < mfp_pkg::BND_BYTES)
			v = boundary[k*8 +: 8];
		return v;
	endfunction

	function automatic mfp_pkg::bundle_t add(input mfp_pkg::bundle_t bi,
			input mfp_pkg::kind_t k, input logic [7:0] v, input logic f);
		mfp_pkg::bundle_t bo;
		bo = bi;
		if (bi.cnt != 2'd3) begin
			bo.r[bi.cnt].kind   = k;
			bo.r[bi.cnt].byte_v = (k <= mfp_pkg::KIND_DATA) ? v : 8'd0;
			bo.r[bi.cnt].file   = (k == mfp_pkg::KIND_PEND) ? f : 1'b0;
			bo.cnt              = bi.cnt + 2'd1;
		end
		return bo;
	endfunction

	logic [LW-1:0]   eff;
	logic [FW-1:0]   wlen, fc, nfill;
	logic [5:0]      mnext;
	logic            drop, hit, plain;
	mfp_pkg::kind_t  qkind;

	always_comb begin
		// clamp boundary length to 1..MAX
		eff = LW'(boundary_len);
		if (eff == '0)
			eff = LW'(1);
		if (eff > LW'(MAX_BOUNDARY_BYTES))
			eff = LW'(MAX_BOUNDARY_BYTES);
		wlen  = FW'(eff) + FW'(4);
		fc    = (fill_q >= FW'(WIN)) ? FW'(WIN - 1) : fill_q;
		nfill = fc + FW'(1);
		for (int i = 0; i < WIN; i++)
			nw[i] = (FW'(i) == fc) ? byte_value : win_q[i];
		hit = nw[0] == mfp_pkg::CHR_CR && nw[1] == mfp_pkg::CHR_LF &&
		      nw[2] == mfp_pkg::CHR_DASH && nw[3] == mfp_pkg::CHR_DASH;
		for (int k = 0; k < MAX_BOUNDARY_BYTES; k++)
			if (LW'(k) < eff && nw[4+k] != bnd_at(k))
				hit = 1'b0;
	end

	always_comb begin
		ph_d    = ph_q;
		match_d = match_q;
		skip_d  = skip_q;
		inq_d   = inq_q;
		take_d  = take_q;
		file_d  = file_q;
		cr_d    = cr_q;
		fill_d  = fill_q;
		win_d   = win_q;
		bundle  = '0;
		drop    = 1'b0;
		plain   = 1'b0;
		mnext   = match_q + 6'd1;
		qkind   = take_q ? mfp_pkg::KIND_NAME : mfp_pkg::KIND_FILE;
		unique case (ph_q)
			mfp_pkg::PH_DASH1: begin
				if (byte_value == mfp_pkg::CHR_DASH)
					ph_d = mfp_pkg::PH_DASH2;
			end
			mfp_pkg::PH_DASH2: begin
				if (byte_value == mfp_pkg::CHR_DASH) begin
					ph_d    = mfp_pkg::PH_BOUND;
					match_d = 6'd0;
				end else
					ph_d = mfp_pkg::PH_DASH1;
			end
			mfp_pkg::PH_BOUND: begin
				if (byte_value != bnd_at(int'(match_q)))
					drop = 1'b1;
				else if (LW'(mnext) >= eff) begin
					match_d = 6'd0;
					cr_d    = 1'b0;
					ph_d    = mfp_pkg::PH_AFTER;
				end else
					match_d = mnext;
			end
			mfp_pkg::PH_AFTER: begin
				if (cr_q) begin
					if (byte_value == mfp_pkg::CHR_LF) begin
						cr_d    = 1'b0;
						match_d = 6'd0;
						ph_d    = mfp_pkg::PH_DISP;
					end else
						drop = 1'b1;
				end else if (byte_value == mfp_pkg::CHR_CR)
					cr_d = 1'b1;
				else if (byte_value == mfp_pkg::CHR_DASH)
					ph_d = mfp_pkg::PH_AFTER_DASH;
				else
					drop = 1'b1;
			end
			mfp_pkg::PH_AFTER_DASH: begin
				if (byte_value == mfp_pkg::CHR_DASH) begin
					bundle = add(bundle, mfp_pkg::KIND_BEND, 8'd0, 1'b0);
					ph_d   = mfp_pkg::PH_END;
				end else
					drop = 1'b1;
			end
			mfp_pkg::PH_DISP: begin
				if (match_q >= 6'(mfp_pkg::DISP_LEN) ||
				    lower(byte_value) != mfp_pkg::disp_char(match_q))
					drop = 1'b1;
				else if (mnext == 6'(mfp_pkg::DISP_LEN)) begin
					match_d = 6'd0;
					skip_d  = 4'(mfp_pkg::DISP_SKIP);
					file_d  = 1'b0;
					inq_d   = 1'b0;
					take_d  = 1'b1;
					ph_d    = mfp_pkg::PH_SKIP;
				end else
					match_d = mnext;
			end
			mfp_pkg::PH_SKIP: begin
				if (skip_q <= 4'd1) begin
					skip_d = 4'd0;
					cr_d   = 1'b0;
					ph_d   = file_q ? mfp_pkg::PH_TYPE : mfp_pkg::PH_CDVAL;
				end else
					skip_d = skip_q - 4'd1;
			end
			mfp_pkg::PH_CDVAL: begin
				plain = 1'b1;
				if (cr_q) begin
					cr_d = 1'b0;
					if (byte_value == mfp_pkg::CHR_LF) begin
						match_d = 6'd0;
						ph_d    = mfp_pkg::PH_LINE2;
						plain   = 1'b0;
					end else if (inq_q)
						bundle = add(bundle, qkind, mfp_pkg::CHR_CR, 1'b0);
				end
			end
			mfp_pkg::PH_CDVAL_EQ: begin
				ph_d = mfp_pkg::PH_CDVAL;
				if (byte_value == mfp_pkg::CHR_QUOTE)
					inq_d = 1'b1;
				else begin
					if (inq_q)
						bundle = add(bundle, qkind, mfp_pkg::CHR_EQ, 1'b0);
					plain = 1'b1;
				end
			end
			mfp_pkg::PH_LINE2: begin
				if (cr_q) begin
					cr_d = 1'b0;
					if (byte_value == mfp_pkg::CHR_LF) begin
						file_d = 1'b0;
						fill_d = '0;
						ph_d   = mfp_pkg::PH_DATA;
					end else
						drop = 1'b1;
				end else if (match_q == 6'd0 && byte_value == mfp_pkg::CHR_CR)
					cr_d = 1'b1;
				else if (match_q >= 6'(mfp_pkg::CTYPE_LEN) ||
				         lower(byte_value) != mfp_pkg::ctype_char(match_q))
					drop = 1'b1;
				else if (mnext == 6'(mfp_pkg::CTYPE_LEN)) begin
					match_d = 6'd0;
					file_d  = 1'b1;
					skip_d  = 4'(mfp_pkg::CTYPE_SKIP);
					ph_d    = mfp_pkg::PH_SKIP;
				end else
					match_d = mnext;
			end
			mfp_pkg::PH_TYPE: begin
				if (cr_q && byte_value == mfp_pkg::CHR_LF) begin
					cr_d = 1'b0;
					ph_d = mfp_pkg::PH_TYPE_END;
				end else begin
					if (cr_q)
						bundle = add(bundle, mfp_pkg::KIND_TYPE, mfp_pkg::CHR_CR, 1'b0);
					if (byte_value == mfp_pkg::CHR_CR)
						cr_d = 1'b1;
					else begin
						cr_d   = 1'b0;
						bundle = add(bundle, mfp_pkg::KIND_TYPE, byte_value, 1'b0);
					end
				end
			end
			mfp_pkg::PH_TYPE_END: begin
				if (cr_q) begin
					cr_d = 1'b0;
					if (byte_value == mfp_pkg::CHR_LF) begin
						fill_d = '0;
						ph_d   = mfp_pkg::PH_DATA;
					end else
						drop = 1'b1;
				end else if (byte_value == mfp_pkg::CHR_CR)
					cr_d = 1'b1;
				else
					drop = 1'b1;
			end
			mfp_pkg::PH_DATA: begin
				for (int i = 0; i < WIN; i++)
					win_d[i] = nw[i];
				fill_d = nfill;
				if (nfill >= wlen) begin
					if (hit) begin
						bundle  = add(bundle, mfp_pkg::KIND_PEND, 8'd0, file_q);
						fill_d  = '0;
						file_d  = 1'b0;
						cr_d    = 1'b0;
						match_d = 6'd0;
						ph_d    = mfp_pkg::PH_AFTER;
					end else begin
						bundle = add(bundle, mfp_pkg::KIND_DATA, nw[0], 1'b0);
						for (int i = 0; i < WIN - 1; i++)
							win_d[i] = nw[i+1];
						fill_d = nfill - FW'(1);
					end
				end
			end
			mfp_pkg::PH_END: begin
			end
			default: drop = 1'b1;
		endcase

		// ordinary byte inside the disposition line
		if (plain) begin
			if (byte_value == mfp_pkg::CHR_CR)
				cr_d = 1'b1;
			else if (byte_value == mfp_pkg::CHR_EQ)
				ph_d = mfp_pkg::PH_CDVAL_EQ;
			else if (byte_value == mfp_pkg::CHR_QUOTE) begin
				inq_d  = 1'b0;
				take_d = ~take_q;
			end else if (inq_q)
				bundle = add(bundle, qkind, byte_value, 1'b0);
		end

		if (body_last && !drop && ph_d != mfp_pkg::PH_END)
			bundle = add(bundle, mfp_pkg::KIND_TRUNC, 8'd0, 1'b0);
		else if (body_last && drop)
			bundle = add(bundle, mfp_pkg::KIND_TRUNC, 8'd0, 1'b0);

		if (drop || body_last) begin
			ph_d    = mfp_pkg::PH_DASH1;
			match_d = 6'd0;
			skip_d  = 4'd0;
			inq_d   = 1'b0;
			take_d  = 1'b1;
			file_d  = 1'b0;
			cr_d    = 1'b0;
			fill_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= mfp_pkg::PH_DASH1;
			match_q <= 6'd0;
			skip_q  <= 4'd0;
			inq_q   <= 1'b0;
			take_q  <= 1'b1;
			file_q  <= 1'b0;
			cr_q    <= 1'b0;
			fill_q  <= '0;
		end else if (accept) begin
			ph_q    <= ph_d;
			match_q <= match_d;
			skip_q  <= skip_d;
			inq_q   <= inq_d;
			take_q  <= take_d;
			file_q  <= file_d;
			cr_q    <= cr_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			win_q <= win_d;
	end
endmodule
`default_nettype wire

// ===== sv/mfp_queue.sv =====
// Short bundle queue between the parser front and the result back end.
`default_nettype none
module mfp_queue #(
	parameter int DEPTH = mfp_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  mfp_pkg::bundle_t       wdata,
	output logic                   full,
	input  wire logic              rd,
	output logic                   nonempty,
	output mfp_pkg::bundle_t       rdata
);
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mfp_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (wr && !rd)
				cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

// ===== sv/mfp_back.sv =====
// Back end: unpacks bundles into single results behind an output register.
`default_nettype none
module mfp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  mfp_pkg::bundle_t   head,
	output logic               head_pop,
	output logic               empty,
	input  wire logic          pop,
	output logic [2:0]         kind,
	output logic [7:0]         out_byte,
	output logic               part_is_file,
	output logic               run_last
);
	logic          out_v_q;
	logic [1:0]    idx_q;
	logic          load, at_end;
	mfp_pkg::res_t cur;

	assign cur      = head.r[idx_q];
	assign at_end   = idx_q == head.cnt - 2'd1;
	assign load     = head_valid && (!out_v_q || pop);
	assign head_pop = load && at_end;
	assign empty    = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			out_v_q <= 1'b1;
			idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (pop)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind         <= cur.kind;
			out_byte     <= cur.byte_v;
			part_is_file <= cur.file;
			run_last     <= at_end;
		end
	end
endmodule
`default_nettype wire

// ===== sv/multipart_form_parser.sv =====
// Top level of the multipart form parser: configuration registers and the three stages.
//
// Usage: body bytes enter on push/full with byte_value and body_last; a word is
// taken at an edge with push high and full low. Results leave on empty/pop
// (kind, out_byte, part_is_file, run_last); the head result is valid while
// empty is low and is taken at an edge with pop high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is the boundary length, 1 to 6 the boundary words.
// Write it only while the block is idle.
// Throughput: one body byte per cycle while full is low; the parser decides each
// byte combinationally, including the full parallel compare of the content window
// against CRLF--boundary. Results leave at one per cycle while pop is high, so the
// results of a byte that raises two or three leave one after another.
// Path: a byte's results pass through the bundle queue, then the output register.
// Stall: a held result only blocks the output register; bytes keep flowing
// until the bundle queue between parser and output fills, then full rises.
// Reset: parser state, queue and output valid flag clear; boundary length reads
// 1 and the boundary words zero. No clearing pass is needed.
`default_nettype none
module multipart_form_parser #(
	parameter int MAX_BOUNDARY_BYTES = mfp_pkg::MAX_BOUNDARY_BYTES,
	parameter int QUEUE_DEPTH        = mfp_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  byte_value,
	input  wire logic        body_last,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [7:0]       out_byte,
	output logic             part_is_file,
	output logic             run_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	logic [5:0]                            len_q;
	logic [mfp_pkg::BND_BYTES*8-1:0]       bnd_q;
	logic                                  accept, head_valid, head_pop;
	mfp_pkg::bundle_t                      bundle, head;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Hold boundary registers; the word at index w covers bytes 8(w-1) to 8(w-1)+7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 6'd1;
			bnd_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == mfp_pkg::REG_LEN)
				len_q <= cfg_data[5:0];
			else if (cfg_index >= mfp_pkg::REG_WORD0 && cfg_index <= mfp_pkg::REG_WORD5)
				bnd_q[(int'(cfg_index) - 1)*64 +: 64] <= cfg_data;
		end
	end

	mfp_front #(.MAX_BOUNDARY_BYTES(MAX_BOUNDARY_BYTES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_value   (byte_value),
		.body_last    (body_last),
		.boundary_len (len_q),
		.boundary     (bnd_q),
		.bundle       (bundle)
	);

	// Advance only bundles that carry results
	mfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (accept && bundle.cnt != 2'd0),
		.wdata    (bundle),
		.full     (full),
		.rd       (head_pop),
		.nonempty (head_valid),
		.rdata    (head)
	);

	mfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.head_pop     (head_pop),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_byte     (out_byte),
		.part_is_file (part_is_file),
		.run_last     (run_last)
	);
endmodule
`default_nettype wire

// ===== sv/mfp_checker.sv =====
// Port-level checks for the multipart form parser, bound to the top level.
`default_nettype none
module mfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [2:0] kind,
	input wire logic [7:0] out_byte,
	input wire logic       part_is_file
);
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown on leaving reset");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(out_byte)))
		else $error("stalled result changed");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> kind <= mfp_pkg::KIND_TRUNC)
		else $error("bad kind");
	a_marker_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == mfp_pkg::KIND_PEND || kind == mfp_pkg::KIND_BEND ||
		            kind == mfp_pkg::KIND_TRUNC)) |-> out_byte == 8'd0)
		else $error("marker carries a byte");
	a_file_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && part_is_file) |-> kind == mfp_pkg::KIND_PEND)
		else $error("file flag outside part end");
endmodule

bind multipart_form_parser mfp_checker u_mfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.kind         (kind),
	.out_byte     (out_byte),
	.part_is_file (part_is_file)
);
`default_nettype wire

// ===== verif/multipart_form_parser_test.sv =====
// Self-checking testbench for the multipart form parser: directed and random bodies against a local predictor.
`default_nettype none
module multipart_form_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} body_word_t;

	typedef struct {
		mfp_pkg::kind_t kind;
		logic [7:0]     value;
		logic           file;
		logic           last;
	} parse_result_t;

	// DUT connections; the inputs are held at known values from time zero
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic [7:0]  byte_value = 8'd0;
	logic        body_last  = 1'b0;
	logic        pop        = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic [2:0]  cfg_index  = mfp_pkg::REG_LEN;
	logic [63:0] cfg_data   = 64'd0;
	logic        full, empty, part_is_file, run_last, cfg_ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;

	multipart_form_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .byte_value(byte_value), .body_last(body_last),
		.empty(empty), .pop(pop), .kind(kind), .out_byte(out_byte),
		.part_is_file(part_is_file), .run_last(run_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the configuration registers
	logic [5:0]  len_mirror = 6'd1;
	logic [63:0] word_mirror [mfp_pkg::BND_WORDS];

	// Predictor state
	mfp_pkg::phase_t ph;
	int          pos, skip_cnt, quoted, name_side, had_type, cr_held, win_fill;
	logic [7:0]  win [mfp_pkg::MAX_BOUNDARY_BYTES + 4];

	parse_result_t byte_results [$];   // results of the word being predicted
	parse_result_t pending_results [$]; // results still owed by the DUT
	body_word_t    byte_feed [$];       // words waiting to be driven
	logic [7:0]    body_buf [$];        // body under construction

	int  failures = 0;
	int  in_gap = 0, out_gap = 0;
	bit  idle_on = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("multipart_form_parser_test failed");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int span();
		int r;
		r = len_mirror;
		if (r == 0) r = 1;
		if (r > mfp_pkg::MAX_BOUNDARY_BYTES) r = mfp_pkg::MAX_BOUNDARY_BYTES;
		return r;
	endfunction

	function automatic logic [7:0] bnd_at(int k);
		if (k >= mfp_pkg::BND_BYTES) return 8'd0;
		return word_mirror[k / 8][(k % 8) * 8 +: 8];
	endfunction

	function automatic logic [7:0] fold(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	task automatic note(mfp_pkg::kind_t k, logic [7:0] v, logic f);
		parse_result_t r;
		if (byte_results.size() >= 3) return;
		r.kind  = k;
		r.value = (k <= mfp_pkg::KIND_DATA) ? v : 8'd0;
		r.file  = (k == mfp_pkg::KIND_PEND) ? f : 1'b0;
		r.last  = 1'b0;
		byte_results.push_back(r);
	endtask

	task automatic drop_part();
		ph = mfp_pkg::PH_DASH1;
		pos = 0; skip_cnt = 0; quoted = 0; name_side = 1;
		had_type = 0; cr_held = 0; win_fill = 0;
	endtask

	function automatic mfp_pkg::kind_t value_kind();
		return name_side ? mfp_pkg::KIND_NAME : mfp_pkg::KIND_FILE;
	endfunction

	// Ordinary byte inside the disposition line
	task automatic disp_plain(logic [7:0] b);
		if (b == mfp_pkg::CHR_CR) cr_held = 1;
		else if (b == mfp_pkg::CHR_EQ) ph = mfp_pkg::PH_CDVAL_EQ;
		else if (b == mfp_pkg::CHR_QUOTE) begin
			quoted = 0;
			name_side ^= 1;
		end else if (quoted) note(value_kind(), b, 1'b0);
	endtask

	// Slide a content byte through the window; a full CRLF--boundary closes the part
	task automatic window_byte(logic [7:0] b);
		int  bl;
		bit  hit;
		bl = span();
		if (win_fill >= mfp_pkg::MAX_BOUNDARY_BYTES + 4)
			win_fill = mfp_pkg::MAX_BOUNDARY_BYTES + 3;
		win[win_fill] = b;
		win_fill++;
		if (win_fill < bl + 4) return;
		hit = win[0] == mfp_pkg::CHR_CR && win[1] == mfp_pkg::CHR_LF &&
		      win[2] == mfp_pkg::CHR_DASH && win[3] == mfp_pkg::CHR_DASH;
		for (int k = 0; k < bl; k++)
			if (win[4 + k] != bnd_at(k)) hit = 1'b0;
		if (hit) begin
			note(mfp_pkg::KIND_PEND, 8'd0, had_type[0]);
			win_fill = 0; had_type = 0; cr_held = 0; pos = 0;
			ph = mfp_pkg::PH_AFTER;
		end else begin
			note(mfp_pkg::KIND_DATA, win[0], 1'b0);
			for (int k = 0; k < win_fill - 1; k++) win[k] = win[k + 1];
			win_fill--;
		end
	endtask

	task automatic parse_word(logic [7:0] b, logic lst);
		byte_results.delete();
		case (ph)
			mfp_pkg::PH_DASH1: if (b == mfp_pkg::CHR_DASH) ph = mfp_pkg::PH_DASH2;
			mfp_pkg::PH_DASH2: begin
				if (b == mfp_pkg::CHR_DASH) begin
					ph = mfp_pkg::PH_BOUND;
					pos = 0;
				end else ph = mfp_pkg::PH_DASH1;
			end
			mfp_pkg::PH_BOUND: begin
				if (b != bnd_at(pos & 63)) drop_part();
				else begin
					pos = (pos + 1) & 63;
					if (pos >= span()) begin
						pos = 0; cr_held = 0; ph = mfp_pkg::PH_AFTER;
					end
				end
			end
			mfp_pkg::PH_AFTER: begin
				if (cr_held) begin
					if (b == mfp_pkg::CHR_LF) begin
						cr_held = 0; pos = 0; ph = mfp_pkg::PH_DISP;
					end else drop_part();
				end else if (b == mfp_pkg::CHR_CR) cr_held = 1;
				else if (b == mfp_pkg::CHR_DASH) ph = mfp_pkg::PH_AFTER_DASH;
				else drop_part();
			end
			mfp_pkg::PH_AFTER_DASH: begin
				if (b == mfp_pkg::CHR_DASH) begin
					note(mfp_pkg::KIND_BEND, 8'd0, 1'b0);
					ph = mfp_pkg::PH_END;
				end else drop_part();
			end
			mfp_pkg::PH_DISP: begin
				if (pos >= mfp_pkg::DISP_LEN || fold(b) != mfp_pkg::disp_char(pos[5:0]))
					drop_part();
				else begin
					pos++;
					if (pos == mfp_pkg::DISP_LEN) begin
						pos = 0; skip_cnt = mfp_pkg::DISP_SKIP; had_type = 0;
						quoted = 0; name_side = 1; ph = mfp_pkg::PH_SKIP;
					end
				end
			end
			mfp_pkg::PH_SKIP: begin
				if (skip_cnt <= 1) begin
					skip_cnt = 0; cr_held = 0;
					ph = had_type ? mfp_pkg::PH_TYPE : mfp_pkg::PH_CDVAL;
				end else skip_cnt--;
			end
			mfp_pkg::PH_CDVAL: begin
				if (cr_held && b == mfp_pkg::CHR_LF) begin
					cr_held = 0; pos = 0; ph = mfp_pkg::PH_LINE2;
				end else begin
					// a held CR that is not part of CRLF becomes an ordinary byte
					if (cr_held) begin
						cr_held = 0;
						if (quoted) note(value_kind(), mfp_pkg::CHR_CR, 1'b0);
					end
					disp_plain(b);
				end
			end
			mfp_pkg::PH_CDVAL_EQ: begin
				ph = mfp_pkg::PH_CDVAL;
				if (b == mfp_pkg::CHR_QUOTE) quoted = 1;
				else begin
					// an '=' not opening a quote is an ordinary byte
					if (quoted) note(value_kind(), mfp_pkg::CHR_EQ, 1'b0);
					disp_plain(b);
				end
			end
			mfp_pkg::PH_LINE2: begin
				if (cr_held) begin
					cr_held = 0;
					if (b == mfp_pkg::CHR_LF) begin
						had_type = 0; win_fill = 0; ph = mfp_pkg::PH_DATA;
					end else drop_part();
				end else if (pos == 0 && b == mfp_pkg::CHR_CR) cr_held = 1;
				else if (pos >= mfp_pkg::CTYPE_LEN ||
				         fold(b) != mfp_pkg::ctype_char(pos[5:0])) drop_part();
				else begin
					pos++;
					if (pos == mfp_pkg::CTYPE_LEN) begin
						pos = 0; had_type = 1; skip_cnt = mfp_pkg::CTYPE_SKIP;
						ph = mfp_pkg::PH_SKIP;
					end
				end
			end
			mfp_pkg::PH_TYPE: begin
				if (cr_held && b == mfp_pkg::CHR_LF) begin
					cr_held = 0;
					ph = mfp_pkg::PH_TYPE_END;
				end else begin
					if (cr_held) begin
						cr_held = 0;
						note(mfp_pkg::KIND_TYPE, mfp_pkg::CHR_CR, 1'b0);
					end
					if (b == mfp_pkg::CHR_CR) cr_held = 1;
					else note(mfp_pkg::KIND_TYPE, b, 1'b0);
				end
			end
			mfp_pkg::PH_TYPE_END: begin
				if (cr_held) begin
					cr_held = 0;
					if (b == mfp_pkg::CHR_LF) begin
						win_fill = 0; ph = mfp_pkg::PH_DATA;
					end else drop_part();
				end else if (b == mfp_pkg::CHR_CR) cr_held = 1;
				else drop_part();
			end
			mfp_pkg::PH_DATA: window_byte(b);
			mfp_pkg::PH_END: ;
			default: drop_part();
		endcase
		if (lst) begin
			if (ph != mfp_pkg::PH_END) note(mfp_pkg::KIND_TRUNC, 8'd0, 1'b0);
			drop_part();
		end
		if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
	endtask

	// ---------------------------------------------------------------- driver and monitor

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin : drive_bytes
		body_word_t w;
		if (arst_n) begin
			if (push && !full) parse_word(byte_value, body_last);
			// hold the word while full; otherwise advance or idle
			if (!push || !full) begin
				if (in_gap > 0) begin
					in_gap--;
					push <= 1'b0;
				end else if (byte_feed.size() > 0) begin
					w = byte_feed.pop_front();
					push <= 1'b1;
					byte_value <= w.value;
					body_last <= w.last;
					in_gap = pick_gap();
				end else push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		parse_result_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: kind %0d byte %0h", kind, out_byte);
					failures++;
				end else begin
					e = pending_results.pop_front();
					if (kind !== e.kind) begin
						$error("kind: expected %0d, got %0d", e.kind, kind);
						failures++;
					end
					if (out_byte !== e.value) begin
						$error("out_byte: expected %0h, got %0h", e.value, out_byte);
						failures++;
					end
					if (part_is_file !== e.file) begin
						$error("part_is_file: expected %0b, got %0b", e.file, part_is_file);
						failures++;
					end
					if (run_last !== e.last) begin
						$error("run_last: expected %0b, got %0b", e.last, run_last);
						failures++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				out_gap = pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic reg_write(logic [2:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mfp_pkg::REG_LEN) len_mirror = data[5:0];
		else word_mirror[idx - mfp_pkg::REG_WORD0] = data;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_boundary(logic [5:0] len, logic [63:0] fill, bit rnd);
		reg_write(mfp_pkg::REG_LEN, {58'd0, len});
		for (int i = 0; i < mfp_pkg::BND_WORDS; i++)
			reg_write(mfp_pkg::REG_WORD0 + i[2:0], rnd ? {$urandom, $urandom} : fill);
	endtask

	// Wait until every word is in and every result out, then let the pipe drain
	task automatic settle();
		while (byte_feed.size() > 0 || push || pending_results.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic feed(logic [7:0] v, logic l);
		body_word_t w;
		w.value = v;
		w.last  = l;
		byte_feed.push_back(w);
	endtask

	task automatic put_text(string s, bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
			body_buf.push_back(c);
		end
	endtask

	task automatic put_crlf();
		body_buf.push_back(mfp_pkg::CHR_CR);
		body_buf.push_back(mfp_pkg::CHR_LF);
	endtask

	task automatic put_marker(int n);
		for (int k = 0; k < n; k++) body_buf.push_back(bnd_at(k));
	endtask

	task automatic put_quoted();
		logic [7:0] c;
		body_buf.push_back(mfp_pkg::CHR_QUOTE);
		repeat ($urandom_range(1, 4)) begin
			c = $urandom_range(33, 126);
			if (c == mfp_pkg::CHR_QUOTE) c = "#";
			body_buf.push_back(c);
		end
		body_buf.push_back(mfp_pkg::CHR_QUOTE);
	endtask

	// One body: mostly well formed parts with random content, sometimes damaged or cut
	task automatic make_body();
		int bl, cut;
		bl = span();
		body_buf.delete();
		put_text("--", 0);
		put_marker(bl);
		repeat ($urandom_range(1, 2)) begin
			put_crlf();
			put_text("content-disposition", 1);
			put_text(": form-data; ", 0);
			put_text("name=", 0);
			put_quoted();
			if ($urandom_range(0, 1)) begin
				put_text("; filename=", 0);
				put_quoted();
			end
			put_crlf();
			if ($urandom_range(0, 1)) begin
				put_text("content-type", 1);
				put_text(": ", 0);
				repeat ($urandom_range(1, 5)) body_buf.push_back($urandom_range(33, 126));
				put_crlf();
			end
			put_crlf();
			repeat ($urandom_range(0, 12)) begin
				case ($urandom_range(0, 9))
					0: body_buf.push_back(mfp_pkg::CHR_CR);
					1: body_buf.push_back(mfp_pkg::CHR_LF);
					2: body_buf.push_back(mfp_pkg::CHR_DASH);
					3: body_buf.push_back(bnd_at($urandom_range(0, bl - 1)));
					default: body_buf.push_back($urandom_range(0, 255));
				endcase
			end
			if ($urandom_range(0, 3) == 0) begin
				// near miss on the closing marker
				put_crlf();
				put_text("--", 0);
				put_marker($urandom_range(0, bl - 1));
				body_buf.push_back($urandom_range(0, 255));
			end
			put_crlf();
			put_text("--", 0);
			put_marker(bl);
		end
		put_text("--", 0);
		repeat ($urandom_range(0, 3)) body_buf.push_back($urandom_range(0, 255));
		if ($urandom_range(0, 5) == 0)
			body_buf[$urandom_range(0, body_buf.size() - 1)] = $urandom_range(0, 255);
		cut = body_buf.size();
		if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, body_buf.size());
		for (int i = 0; i < cut; i++) feed(body_buf[i], i == cut - 1);
	endtask

	initial begin : run
		logic [5:0] lens [4];
		int sent, p;
		foreach (word_mirror[i]) word_mirror[i] = 64'd0;
		drop_part();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one-byte boundary of all ones, exercising the waiting and end paths
		load_boundary(6'd1, 64'hffff_ffff_ffff_ffff, 0);
		put_text("x-y--A", 0);                  // garbage, lone dash, bad boundary
		foreach (body_buf[i]) feed(body_buf[i], 1'b0);
		body_buf.delete();
		feed(mfp_pkg::CHR_DASH, 0); feed(mfp_pkg::CHR_DASH, 0); feed(8'hff, 0);
		feed(mfp_pkg::CHR_DASH, 0); feed(mfp_pkg::CHR_DASH, 0);   // body end
		feed(8'h7a, 0); feed(8'h00, 1);          // ignored tail, then last
		feed(mfp_pkg::CHR_DASH, 1);              // body cut short
		feed(mfp_pkg::CHR_DASH, 0); feed(mfp_pkg::CHR_DASH, 0); feed(8'hff, 0);
		feed(mfp_pkg::CHR_CR, 0); feed(8'h41, 1);   // broken CRLF, then cut
		settle();

		// Random bodies until the byte budget is spent, cycling boundary lengths
		lens = '{6'd1, 6'd6, 6'($urandom_range(2, 16)), 6'd3};
		sent = 0;
		p = 0;
		while (sent < 140) begin
			load_boundary(lens[p % 4], 64'd0, (p % 4) != 0);
			idle_on = (p % 3) != 2;
			make_body();
			sent += byte_feed.size();
			settle();
			p++;
		end

		while (pending_results.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0) $display("multipart_form_parser_test passed");
		else $display("multipart_form_parser_test failed");
		$finish;
	end

endmodule
`default_nettype wire
